/* sv/psg_pkg.sv */
// shared types and constants for the performance-state governor
package psg_pkg;

    localparam int NUM_UNITS = 64;
    localparam int UNIT_W    = $clog2(NUM_UNITS);
    localparam int STATE_W   = 5;
    localparam int COUNT_W   = 17;
    localparam int TEMP_W    = 8;
    localparam int UTIL_W    = 7;
    localparam int HOLD_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 64;

    localparam logic [COUNT_W-1:0]   IDLE_MAX   = {COUNT_W{1'b1}};
    localparam logic [STATE_W-1:0]   EXIT_STATE = 5'd16;

    localparam logic [TEMP_W-1:0]    RST_TEMP_THRESHOLD = 8'd80;
    localparam logic [UTIL_W-1:0]    RST_UTIL_THRESHOLD = 7'd0;
    localparam logic [HOLD_W-1:0]    RST_HOLD_COUNT     = 16'd30;
    localparam logic [STATE_W-1:0]   RST_HIGH_STATE     = 5'd16;
    localparam logic [STATE_W-1:0]   RST_LOW_STATE      = 5'd8;
    localparam logic [NUM_UNITS-1:0] RST_MANAGED_MASK   = {NUM_UNITS{1'b1}};

    typedef enum logic [1:0] {
        MODE_SAMPLE = 2'd0,
        MODE_START  = 2'd1,
        MODE_EXIT   = 2'd2,
        MODE_NOP    = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEMP_THRESHOLD = 3'd0,
        CFG_UTIL_THRESHOLD = 3'd1,
        CFG_HOLD_COUNT     = 3'd2,
        CFG_HIGH_STATE     = 3'd3,
        CFG_LOW_STATE      = 3'd4,
        CFG_MANAGED_MASK   = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [STATE_W-1:0] state;
        logic [COUNT_W-1:0] count;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

/* sv/psg_ram.sv */
// generic single-write, single-read ram with registered read data
module psg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/perf_state_governor.sv */
// per-unit performance-state governor with idle hysteresis
//
//  channel | valid        | stall        | payload
//  --------+--------------+--------------+-----------------------------------------------
//  in      | i_in_valid   | o_in_stall   | i_mode, i_unit_index, i_temperature, i_utilization
//  out     | o_out_valid  | i_out_stall  | o_result_unit, o_perf_state, o_changed
//  cfg     | i_cfg_we     | (none)       | i_cfg_index, i_cfg_data
//
// one item per cycle when the output does not stall; a taken item is held in the evaluate
// stage while the ram is read, and its result is then loaded into the result register.
// the per-unit state ram is read as an item is taken; a write-back register
// forwards the latest update so back-to-back items on one unit see fresh state.
// synchronous active-low reset clears the valid bits of the state ram at once,
// so unwritten units read as state 0, count 0; no clearing pass is needed.
// a stalled output holds the evaluate stage, which then stalls the input.
module perf_state_governor
    import psg_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_mode,
    input  logic [UNIT_W-1:0]    i_unit_index,
    input  logic [TEMP_W-1:0]    i_temperature,
    input  logic [UTIL_W-1:0]    i_utilization,

    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [UNIT_W-1:0]    o_result_unit,
    output logic [STATE_W-1:0]   o_perf_state,
    output logic                 o_changed,

    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    // configuration
    logic [TEMP_W-1:0]    r_temp_threshold;
    logic [UTIL_W-1:0]    r_util_threshold;
    logic [HOLD_W-1:0]    r_hold_count;
    logic [STATE_W-1:0]   r_high_state;
    logic [STATE_W-1:0]   r_low_state;
    logic [NUM_UNITS-1:0] r_managed_mask;

    // evaluate stage
    logic                 r_ex_vld;
    t_mode                r_ex_mode;
    logic [UNIT_W-1:0]    r_ex_unit;
    logic [TEMP_W-1:0]    r_ex_temp;
    logic [UTIL_W-1:0]    r_ex_util;

    // write-back forwarding
    logic                 r_wb_vld;
    logic [UNIT_W-1:0]    r_wb_unit;
    t_entry               r_wb_entry;

    logic [NUM_UNITS-1:0] r_ent_vld;

    // result register
    logic                 r_out_vld;
    logic [UNIT_W-1:0]    r_out_unit;
    logic [STATE_W-1:0]   r_out_state;
    logic                 r_out_changed;

    logic                 in_xfer;
    logic                 advance;
    t_entry               ram_rdata;
    t_entry               cur;
    t_entry               n_entry;
    logic                 n_changed;

    assign advance    = r_ex_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_ex_vld && !advance;
    assign in_xfer    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_threshold <= RST_TEMP_THRESHOLD;
            r_util_threshold <= RST_UTIL_THRESHOLD;
            r_hold_count     <= RST_HOLD_COUNT;
            r_high_state     <= RST_HIGH_STATE;
            r_low_state      <= RST_LOW_STATE;
            r_managed_mask   <= RST_MANAGED_MASK;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_TEMP_THRESHOLD: r_temp_threshold <= i_cfg_data[TEMP_W-1:0];
                CFG_UTIL_THRESHOLD: r_util_threshold <= i_cfg_data[UTIL_W-1:0];
                CFG_HOLD_COUNT:     r_hold_count     <= i_cfg_data[HOLD_W-1:0];
                CFG_HIGH_STATE:     r_high_state     <= i_cfg_data[STATE_W-1:0];
                CFG_LOW_STATE:      r_low_state      <= i_cfg_data[STATE_W-1:0];
                CFG_MANAGED_MASK:   r_managed_mask   <= i_cfg_data[NUM_UNITS-1:0];
                default: ;
            endcase
        end
    end

    psg_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_UNITS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (advance),
        .i_waddr (r_ex_unit),
        .i_wdata (n_entry),
        .i_re    (in_xfer),
        .i_raddr (i_unit_index),
        .o_rdata (ram_rdata)
    );

    // current entry: forwarded update first, then ram, else reset value
    always_comb begin
        if (r_wb_vld && (r_wb_unit == r_ex_unit)) begin
            cur = r_wb_entry;
        end else if (r_ent_vld[r_ex_unit]) begin
            cur = ram_rdata;
        end else begin
            cur = '0;
        end
    end

    always_comb begin
        logic               cmd;
        logic [STATE_W-1:0] cmd_state;
        logic               clr;
        logic               inc;
        logic [COUNT_W-1:0] cnt;

        cmd       = 1'b0;
        cmd_state = r_low_state;
        clr       = 1'b0;
        inc       = 1'b0;
        unique case (r_ex_mode)
            MODE_START: begin
                cmd = 1'b1;
            end
            MODE_EXIT: begin
                cmd       = 1'b1;
                cmd_state = EXIT_STATE;
            end
            MODE_SAMPLE: begin
                priority if (r_ex_temp > r_temp_threshold) begin
                    cmd = (cur.state != r_low_state);
                end else if (r_ex_util > r_util_threshold) begin
                    cmd_state = r_high_state;
                    cmd       = (cur.state != r_high_state);
                    clr       = (cur.state == r_high_state);
                end else if (cur.state != r_low_state) begin
                    cmd = (cur.count > {1'b0, r_hold_count});
                    inc = 1'b1;
                end else begin
                    cmd = 1'b0;
                end
            end
            MODE_NOP: ;
            default: ;
        endcase

        n_changed = cmd && r_managed_mask[r_ex_unit];
        cnt       = (n_changed || clr) ? '0 : cur.count;
        // idle counter saturates
        if (inc && (cnt != IDLE_MAX)) begin
            cnt = cnt + 1'b1;
        end
        n_entry.state = n_changed ? cmd_state : cur.state;
        n_entry.count = cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ex_vld  <= 1'b0;
            r_wb_vld  <= 1'b0;
            r_ent_vld <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_ex_vld <= 1'b1;
            end else if (advance) begin
                r_ex_vld <= 1'b0;
            end
            if (advance) begin
                r_wb_vld             <= 1'b1;
                r_ent_vld[r_ex_unit] <= 1'b1;
                r_out_vld            <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_ex_mode <= t_mode'(i_mode);
            r_ex_unit <= i_unit_index;
            r_ex_temp <= i_temperature;
            r_ex_util <= i_utilization;
        end
        if (advance) begin
            r_wb_unit     <= r_ex_unit;
            r_wb_entry    <= n_entry;
            r_out_unit    <= r_ex_unit;
            r_out_state   <= n_entry.state;
            r_out_changed <= n_changed;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_result_unit = r_out_unit;
    assign o_perf_state  = r_out_state;
    assign o_changed     = r_out_changed;

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_ex_vld |-> !o_in_stall)
        else $error("input stalled with empty evaluate stage");

    a_fwd_after_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> (r_wb_vld && r_wb_unit == $past(r_ex_unit)))
        else $error("forwarding register missed a write-back");

    a_entry_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_ent_vld[$past(r_ex_unit)])
        else $error("written unit not marked valid");

    a_changed_managed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_changed) |-> r_managed_mask[o_result_unit])
        else $error("change reported for unmanaged unit");

    a_out_follows_ex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_out_valid)
        else $error("evaluated item produced no result");

endmodule
